[design/pwmix_pkg.sv]
// Shared constants, types and the sine quarter-wave table for the waveform mixer.
// No dependencies; every other design file imports this package.
package pwmix_pkg;

    localparam int VOICES       = 16;
    localparam int SINE_BITS    = 10;
    localparam int SINE_ENTRIES = 1 << SINE_BITS;

    localparam int IDX_W      = 4;
    localparam int STEP_W     = 32;
    localparam int AMP_W      = 11;
    localparam int WAVE_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int VAL_W      = AMP_W + 1;
    localparam int CNT_W      = (VOICES > 4) ? $clog2(VOICES) : 2;
    localparam int ACC_W      = VAL_W + $clog2(VOICES);
    localparam int SUM_W      = (ACC_W > SAMPLE_W + 1) ? ACC_W : SAMPLE_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    localparam logic [AMP_W-1:0]  AMP_RESET = 11'd1750;
    localparam logic [STEP_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [STEP_W-1:0] QTR_TURN  = 32'h4000_0000;

    // operation codes carried in tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // waveform codes
    localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRI    = 2'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP  = 2'd1;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] phase;
    } t_voice;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef logic [15:0] t_sine_rom [SINE_ENTRIES];

    // Quarter sine in Q0.16 from a Taylor series in Q2.30, rounded half up.
    function automatic t_sine_rom build_sine();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        int          k;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            x    = (64'(i) * 64'd1686629713) >> SINE_BITS;
            term = x;
            sum  = longint'(x);
            for (k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum = sum - longint'(term);
                else            sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            if (sum > (64'sd1 <<< 30) - 1) sum = (64'sd1 <<< 30) - 1;
            sum = (sum + 8192) >>> 14;
            if (sum > 65535) sum = 65535;
            rom[i] = sum[15:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

endpackage

[design/polyphonic_waveform_mixer_top.sv]
// Polyphonic waveform mixer top level: control sequencer, cell ring, mixer.
// Depends on pwmix_pkg, pwmix_cell and pwmix_wave.
//
// Usage: words enter on the s_axis channel. tuser carries the operation
// (tick or set voice increment); tdata carries voice_index and the 32-bit
// phase_increment. A tick returns one signed 16-bit sample on m_axis; a
// set returns nothing. The cfg channel writes waveform_select (index 0)
// and voice_amplitude (index 1) and is always ready; write it only while
// the block is idle.
// Each voice lives in a cell of a ring. A tick rotates the ring once, one
// cell per cycle, through a shared waveform unit; each voice's phase is advanced
// as it re-enters at the tail, and the mixer sums the values and saturates.
// Sequence: a tick rotates through all the cells, drains the waveform unit,
// loads the output register and returns to idle to accept. A set uses three
// passes through one 16x16 multiplier to form sample_count * increment for
// the new phase.
// Reset clears the sample counter, all increments and phases (voices
// silent), and the registers to sine and amplitude 1750. When the receiver
// stalls, the sample is held in the output register; the next word is still
// accepted, and a later tick waits in its final step until the slot frees.
module polyphonic_waveform_mixer_top
    import pwmix_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,  // [3:0] voice_index, [35:4] phase_increment
    input  logic [0:0]             i_s_axis_tuser,  // [0] operation
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,  // [15:0] sample
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic [STEP_W-1:0]        r_count;
    logic [IDX_W-1:0]         r_idx;
    logic [STEP_W-1:0]        r_step;
    logic [STEP_W-1:0]        r_phs;
    logic [STEP_W-1:0]        n_phs;
    logic signed [SUM_W-1:0]  r_acc;
    logic [WAVE_W-1:0]        r_wave;
    logic [AMP_W-1:0]         r_amp;
    logic                     r_m_valid;
    logic [SAMPLE_W-1:0]      r_m_data;

    logic                     s_acc;
    logic [15:0]              mul_a;
    logic [15:0]              mul_b;
    logic [31:0]              mul_p;
    logic                     load_go;
    logic                     out_go;
    logic [SAMPLE_W-1:0]      sat;
    t_voice                   voice [VOICES];
    t_voice                   wrap;
    t_voice                   load_v;
    logic                     wv_valid;
    logic                     wv_valid_q;
    logic signed [VAL_W-1:0]  wv_value;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // new phase = low 32 bits of sample_count * increment, from 16x16 partials
    always_comb begin
        mul_a = (r_cnt == CNT_W'(2)) ? r_count[31:16] : r_count[15:0];
        mul_b = (r_cnt == CNT_W'(1)) ? r_step[31:16] : r_step[15:0];
        mul_p = mul_a * mul_b;
        if (r_cnt == '0) begin
            n_phs = mul_p;
        end else begin
            n_phs = r_phs + {mul_p[15:0], 16'h0000};
        end
    end

    assign load_go     = (r_state == ST_MUL) && (r_cnt == CNT_W'(2));
    assign load_v.step  = r_step;
    assign load_v.phase = n_phs;

    // head cell feeds the waveform unit and re-enters at the tail advanced
    assign wrap.step  = voice[0].step;
    assign wrap.phase = voice[0].phase + voice[0].step;
    assign wv_valid   = (r_state == ST_SHIFT) && (voice[0].step != '0);

    for (genvar g = 0; g < VOICES; g++) begin : g_cell
        t_cell_ctl ctl;
        t_voice    nbr;
        assign ctl.shift = (r_state == ST_SHIFT);
        assign ctl.load  = load_go && (32'(r_idx) == g);
        if (g == VOICES - 1) begin : g_tail
            assign nbr = wrap;
        end else begin : g_body
            assign nbr = voice[g+1];
        end
        pwmix_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_nbr   (nbr),
            .i_load  (load_v),
            .o_voice (voice[g])
        );
    end

    pwmix_wave u_wave (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (wv_valid),
        .i_phase    (voice[0].phase),
        .i_wave_sel (r_wave),
        .i_amp      (r_amp),
        .o_valid    (wv_valid_q),
        .o_value    (wv_value)
    );

    always_comb begin
        if (r_acc > SAT_HI) begin
            sat = 16'h7FFF;
        end else if (r_acc < SAT_LO) begin
            sat = 16'h8000;
        end else begin
            sat = r_acc[SAMPLE_W-1:0];
        end
    end

    assign out_go = (r_state == ST_OUT) && (!r_m_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 1'b1;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (s_acc) begin
                    n_state = (i_s_axis_tuser[0] == OP_SET) ? ST_MUL : ST_SHIFT;
                end
            end
            ST_MUL: begin
                if (r_cnt == CNT_W'(2)) n_state = ST_IDLE;
            end
            ST_SHIFT: begin
                if (r_cnt == CNT_W'(VOICES - 1)) begin
                    n_state = ST_DRAIN;
                    n_cnt   = '0;
                end
            end
            ST_DRAIN: begin
                if (r_cnt == CNT_W'(1)) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_go) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_count   <= '0;
            r_wave    <= WAVE_SINE;
            r_amp     <= AMP_RESET;
            r_m_valid <= 1'b0;
            r_acc     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_WAVE: r_wave <= i_cfg_data[WAVE_W-1:0];
                    REG_AMP:  r_amp  <= i_cfg_data[AMP_W-1:0];
                    default:  ;
                endcase
            end
            if (s_acc) begin
                r_acc <= '0;
            end else if (wv_valid_q) begin
                r_acc <= r_acc + SUM_W'(wv_value);
            end
            if (out_go) begin
                r_m_valid <= 1'b1;
                r_count   <= r_count + 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (s_acc) begin
            r_idx  <= i_s_axis_tdata[IDX_W-1:0];
            r_step <= i_s_axis_tdata[IDX_W +: STEP_W];
        end
        if (r_state == ST_MUL) begin
            r_phs <= n_phs;
        end
        if (out_go) begin
            r_m_data <= sat;
        end
    end

endmodule

[design/pwmix_cell.sv]
// One oscillator cell: holds a voice's phase increment and current phase.
// Depends on pwmix_pkg; chained by the top level into a rotating ring.
module pwmix_cell
    import pwmix_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_voice    i_nbr,
    input  t_voice    i_load,
    output t_voice    o_voice
);

    t_voice r_voice;
    t_voice n_voice;

    always_comb begin
        n_voice = r_voice;
        if (i_ctl.load) begin
            n_voice = i_load;
        end else if (i_ctl.shift) begin
            n_voice = i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice <= '0;
        end else begin
            r_voice <= n_voice;
        end
    end

    assign o_voice = r_voice;

endmodule

[design/pwmix_wave.sv]
// Shared waveform unit: phase to signed voice value in two register stages.
// Depends on pwmix_pkg for the sine table and waveform codes.
module pwmix_wave
    import pwmix_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [STEP_W-1:0]       i_phase,
    input  logic [WAVE_W-1:0]       i_wave_sel,
    input  logic [AMP_W-1:0]        i_amp,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_value
);

    localparam int PROD_W = STEP_W + AMP_W;

    logic                 r_s1_valid;
    logic                 r_s1_neg;
    logic [STEP_W-1:0]    r_s1_opnd;
    logic [WAVE_W-1:0]    r_s1_sel;
    logic                 r_s2_valid;
    logic                 r_s2_neg;
    logic [AMP_W-1:0]     r_s2_mag;

    logic                 n_neg;
    logic [STEP_W-1:0]    n_opnd;
    logic [1:0]           quad;
    logic [SINE_BITS-1:0] sidx;
    logic [SINE_BITS-1:0] midx;
    logic [16:0]          tval;
    logic [STEP_W-1:0]    half_dist;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    scaled;
    logic [AMP_W:0]       mag_ext;

    // stage 1: quadrant/table lookup or distance from half turn
    always_comb begin
        quad = i_phase[STEP_W-1 -: 2];
        sidx = i_phase[STEP_W-3 -: SINE_BITS];
        midx = '0 - sidx;
        if (quad[0]) begin
            tval = (sidx == '0) ? 17'h1_0000 : {1'b0, SINE_ROM[midx]};
        end else begin
            tval = {1'b0, SINE_ROM[sidx]};
        end
        half_dist = (i_phase >= HALF_TURN) ? i_phase - HALF_TURN : HALF_TURN - i_phase;
        case (i_wave_sel)
            WAVE_SINE: begin
                n_opnd = STEP_W'(tval);
                n_neg  = quad[1];
            end
            WAVE_SQUARE: begin
                n_opnd = 32'h0001_0000;
                n_neg  = !(i_phase > HALF_TURN);
            end
            WAVE_TRI: begin
                n_neg  = half_dist < QTR_TURN;
                n_opnd = n_neg ? QTR_TURN - half_dist : half_dist - QTR_TURN;
            end
            default: begin
                n_opnd = half_dist;
                n_neg  = i_phase < HALF_TURN;
            end
        endcase
    end

    // stage 2: scale by amplitude
    always_comb begin
        prod = PROD_W'(r_s1_opnd) * PROD_W'(i_amp);
        case (r_s1_sel)
            WAVE_TRI: scaled = prod >> 30;
            WAVE_SAW: scaled = prod >> 31;
            default:  scaled = prod >> 16;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_neg  <= n_neg;
        r_s1_opnd <= n_opnd;
        r_s1_sel  <= i_wave_sel;
        r_s2_neg  <= r_s1_neg;
        r_s2_mag  <= scaled[AMP_W-1:0];
    end

    assign mag_ext = {1'b0, r_s2_mag};
    assign o_valid = r_s2_valid;
    assign o_value = r_s2_neg ? -$signed(mag_ext) : $signed(mag_ext);

endmodule

[design/pwmix_checker.sv]
// Port-level checks for the waveform mixer, bound to the top level.
// Depends on pwmix_pkg and polyphonic_waveform_mixer_top.
module pwmix_checker
    import pwmix_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    input logic [0:0]            i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled sample holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed under stall");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // an accepted word keeps the input closed in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after accept");

    // a set word never brings a sample into an empty output
    a_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser[0] == OP_SET)
        && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("sample produced by a set word");

    // a tick does not finish straight after its accept
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser[0] == OP_TICK)
        && !o_m_axis_tvalid |=> !o_m_axis_tvalid ##1 !o_m_axis_tvalid)
        else $error("tick result too early");

endmodule

bind polyphonic_waveform_mixer_top pwmix_checker u_pwmix_checker (.*);
